// File: hdl/epoch_reclaim_tracker_top_defines.svh
// ----------------------------------------------------------------------------
// Epoch reclaim tracker assertion macros
// Shared concurrent assertion forms for the tracker RTL.
// ----------------------------------------------------------------------------
`ifndef EPOCH_RECLAIM_TRACKER_TOP_DEFINES_SVH
`define EPOCH_RECLAIM_TRACKER_TOP_DEFINES_SVH

// same-cycle implication
`define ERT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ERT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/ert_pkg.sv
// ----------------------------------------------------------------------------
// ert_pkg
// Types, codes and sizing constants of the epoch reclaim tracker.
// ----------------------------------------------------------------------------
package ert_pkg;

   localparam int READER_SLOTS_DEF = 16;
   localparam int NODE_DEPTH_DEF   = 32;
   localparam int MAX_RESULTS      = 32;
   localparam int FREE_CW          = $clog2(MAX_RESULTS + 1);

   localparam logic [1:0] KIND_TICK    = 2'd0;
   localparam logic [1:0] KIND_REG     = 2'd1;
   localparam logic [1:0] KIND_UNREG   = 2'd2;
   localparam logic [1:0] KIND_RETIRE  = 2'd3;

   localparam logic [2:0] STAT_OK      = 3'd0;
   localparam logic [2:0] STAT_DUP     = 3'd1;
   localparam logic [2:0] STAT_UNKNOWN = 3'd2;
   localparam logic [2:0] STAT_TFULL   = 3'd3;
   localparam logic [2:0] STAT_QFULL   = 3'd4;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] reader_id;
      logic [31:0] node_handle;
   } ert_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        freed_valid;
      logic [31:0] freed_handle;
      logic        last;
      logic [31:0] current_epoch;
   } ert_rsp_type;

   typedef struct packed {
      logic [31:0] handle;
      logic [31:0] epoch;
   } ert_node_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic rd;
   } ert_q_ctl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } ert_q_stat_type;

endpackage

// File: hdl/ert_queue.sv
// ----------------------------------------------------------------------------
// ert_queue
// Retired node FIFO: handle and epoch per entry in one synchronous memory,
// head read through a registered output.
// ----------------------------------------------------------------------------
module ert_queue #(
   parameter int NODE_DEPTH = ert_pkg::NODE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ert_pkg::ert_q_ctl_type q_ctl,
   input  ert_pkg::ert_node_type  push_entry,
   output ert_pkg::ert_node_type  rd_entry,
   output ert_pkg::ert_q_stat_type q_stat
);

`include "epoch_reclaim_tracker_top_defines.svh"

   localparam int PW = $clog2(NODE_DEPTH);
   localparam int CW = $clog2(NODE_DEPTH + 1);

   ert_pkg::ert_node_type node_mem [NODE_DEPTH];
   ert_pkg::ert_node_type rd_ff;

   logic [PW-1:0] head_ff, head_in;
   logic [PW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (q_ctl.push) begin
         node_mem[tail_ff] <= push_entry;
      end
      if (q_ctl.rd) begin
         rd_ff <= node_mem[head_ff];
      end
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (q_ctl.pop) begin
         head_in  = (head_ff == PW'(NODE_DEPTH - 1)) ? '0 : head_ff + PW'(1);
         count_in = count_ff - CW'(1);
      end
      if (q_ctl.push) begin
         tail_in  = (tail_ff == PW'(NODE_DEPTH - 1)) ? '0 : tail_ff + PW'(1);
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   assign rd_entry     = rd_ff;
   assign q_stat.empty = (count_ff == '0);
   assign q_stat.full  = (count_ff == CW'(NODE_DEPTH));

   `ERT_ASSERT_IMP(a_push_not_full, clock, reset, q_ctl.push, !q_stat.full, "push into full queue")
   `ERT_ASSERT_IMP(a_pop_not_empty, clock, reset, q_ctl.pop, !q_stat.empty, "pop from empty queue")
   `ERT_ASSERT_IMP(a_empty_ptrs, clock, reset, count_ff == '0, head_ff == tail_ff, "empty queue with pointer skew")

endmodule

// File: hdl/epoch_reclaim_tracker_top.sv
// ----------------------------------------------------------------------------
// epoch_reclaim_tracker_top
// Epoch-based reclamation tracker: global epoch, reader table in a
// synchronous memory, and a FIFO of retired nodes freed on each tick.
//
//   channel | dir | handshake            | payload
//   req     | in  | req_valid/req_ready  | ert_req_type (kind, reader_id, node_handle)
//   rsp     | out | rsp_valid/rsp_ready  | ert_rsp_type (status .. current_epoch)
//
// One request at a time. Retire: a queue push, or STAT_QFULL on a full
// queue. Register/unregister: a scan of the reader memory. Tick: a scan
// of the reader memory for the oldest reader, then one queue read per freed
// node, closing on an empty queue, the free limit or a blocked head.
// Reset is synchronous; no clearing pass, reader slots carry valid bits.
// A stalled rsp holds the tracker in place; the next request is taken while
// the final response still waits in the output register.
// ----------------------------------------------------------------------------
module epoch_reclaim_tracker_top #(
   parameter int READER_SLOTS = ert_pkg::READER_SLOTS_DEF,
   parameter int NODE_DEPTH   = ert_pkg::NODE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ert_pkg::ert_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ert_pkg::ert_rsp_type rsp_data
);

`include "epoch_reclaim_tracker_top_defines.svh"

   localparam int RAW = (READER_SLOTS > 1) ? $clog2(READER_SLOTS) : 1;
   localparam int SCW = $clog2(READER_SLOTS + 1);
   localparam int NCW = ert_pkg::FREE_CW;

   typedef struct packed {
      logic [15:0] ident;
      logic [31:0] epoch;
   } reader_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FREE_RD,
      ST_FREE_CHK,
      ST_EMIT
   } state_type;

   reader_type reader_mem [READER_SLOTS];
   reader_type rd_ff;
   logic       rd_en;
   logic       wr_en;
   logic [RAW-1:0] rd_addr;

   state_type          state_ff, state_in;
   logic [1:0]         kind_ff, kind_in;
   logic [15:0]        id_ff, id_in;
   logic [31:0]        epoch_ff, epoch_in;
   logic [READER_SLOTS-1:0] active_ff, active_in;
   logic [SCW-1:0]     scan_cnt_ff, scan_cnt_in;
   logic               any_ff, any_in;
   logic [31:0]        oldest_ff, oldest_in;
   logic               found_ff, found_in;
   logic [RAW-1:0]     found_idx_ff, found_idx_in;
   logic [2:0]         status_ff, status_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [31:0]        pend_handle_ff, pend_handle_in;
   logic [NCW-1:0]     freed_cnt_ff, freed_cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   ert_pkg::ert_rsp_type rsp_data_ff, rsp_data_in;

   ert_pkg::ert_q_ctl_type  q_ctl;
   ert_pkg::ert_q_stat_type q_stat;
   ert_pkg::ert_node_type   q_push;
   ert_pkg::ert_node_type   q_rd;

   logic [RAW-1:0] free_idx;
   logic           all_full;
   logic [RAW-1:0] proc_idx;
   logic           proc_active;
   logic           hit;
   logic           found_now;
   logic [RAW-1:0] found_idx_now;
   logic           out_free;
   logic           load;
   logic           node_ok;
   ert_pkg::ert_rsp_type load_data;
   ert_pkg::ert_rsp_type final_rsp;

   ert_queue #(
      .NODE_DEPTH(NODE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .q_ctl     (q_ctl),
      .push_entry(q_push),
      .rd_entry  (q_rd),
      .q_stat    (q_stat)
   );

   // reader table memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         reader_mem[free_idx] <= '{ident: id_ff, epoch: epoch_ff};
      end
      if (rd_en) begin
         rd_ff <= reader_mem[rd_addr];
      end
   end

   // lowest free slot
   always_comb begin
      free_idx = '0;
      for (int i = READER_SLOTS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_idx = RAW'(i);
         end
      end
      all_full = &active_ff;
   end

   assign proc_idx    = RAW'(scan_cnt_ff - SCW'(1));
   assign proc_active = (scan_cnt_ff != '0) && active_ff[proc_idx];
   assign hit         = proc_active && (rd_ff.ident == id_ff);
   assign found_now   = found_ff || hit;
   assign found_idx_now = found_ff ? found_idx_ff : proc_idx;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign node_ok     = !any_ff || (q_rd.epoch < oldest_ff);

   assign q_push.handle = req_data.node_handle;
   assign q_push.epoch  = epoch_ff;

   always_comb begin
      final_rsp.status        = ert_pkg::STAT_OK;
      final_rsp.freed_valid   = pend_valid_ff;
      final_rsp.freed_handle  = pend_valid_ff ? pend_handle_ff : 32'd0;
      final_rsp.last          = 1'b1;
      final_rsp.current_epoch = epoch_ff;
   end

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      id_in          = id_ff;
      epoch_in       = epoch_ff;
      active_in      = active_ff;
      scan_cnt_in    = scan_cnt_ff;
      any_in         = any_ff;
      oldest_in      = oldest_ff;
      found_in       = found_ff;
      found_idx_in   = found_idx_ff;
      status_in      = status_ff;
      pend_valid_in  = pend_valid_ff;
      pend_handle_in = pend_handle_ff;
      freed_cnt_in   = freed_cnt_ff;
      rd_en          = 1'b0;
      rd_addr        = scan_cnt_ff[RAW-1:0];
      wr_en          = 1'b0;
      q_ctl          = '0;
      load           = 1'b0;
      load_data      = final_rsp;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in     = req_data.kind;
               id_in       = req_data.reader_id;
               scan_cnt_in = '0;
               found_in    = 1'b0;
               unique case (req_data.kind)
                  ert_pkg::KIND_TICK: begin
                     if (epoch_ff != '1) begin
                        epoch_in = epoch_ff + 32'd1;
                     end
                     any_in        = 1'b0;
                     oldest_in     = '0;
                     pend_valid_in = 1'b0;
                     freed_cnt_in  = '0;
                     state_in      = ST_SCAN;
                  end
                  ert_pkg::KIND_REG, ert_pkg::KIND_UNREG: begin
                     state_in = ST_SCAN;
                  end
                  ert_pkg::KIND_RETIRE: begin
                     if (q_stat.full) begin
                        status_in = ert_pkg::STAT_QFULL;
                     end else begin
                        q_ctl.push = 1'b1;
                        status_in  = ert_pkg::STAT_OK;
                     end
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_cnt_ff < SCW'(READER_SLOTS)) begin
               rd_en = 1'b1;
            end
            scan_cnt_in = scan_cnt_ff + SCW'(1);
            if (proc_active && (!any_ff || rd_ff.epoch < oldest_ff)) begin
               oldest_in = rd_ff.epoch;
            end
            if (proc_active) begin
               any_in = 1'b1;
            end
            found_in     = found_now;
            found_idx_in = found_idx_now;
            if (scan_cnt_ff == SCW'(READER_SLOTS)) begin
               state_in = ST_EMIT;
               if (kind_ff == ert_pkg::KIND_TICK) begin
                  state_in = ST_FREE_RD;
               end else if (kind_ff == ert_pkg::KIND_REG) begin
                  if (found_now) begin
                     status_in = ert_pkg::STAT_DUP;
                  end else if (all_full) begin
                     status_in = ert_pkg::STAT_TFULL;
                  end else begin
                     wr_en               = 1'b1;
                     active_in[free_idx] = 1'b1;
                     status_in           = ert_pkg::STAT_OK;
                  end
               end else begin
                  if (found_now) begin
                     active_in[found_idx_now] = 1'b0;
                     status_in                = ert_pkg::STAT_OK;
                  end else begin
                     status_in = ert_pkg::STAT_UNKNOWN;
                  end
               end
            end
         end
         ST_FREE_RD: begin
            if (q_stat.empty || freed_cnt_ff == NCW'(ert_pkg::MAX_RESULTS)) begin
               if (out_free) begin
                  load     = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               q_ctl.rd = 1'b1;
               state_in = ST_FREE_CHK;
            end
         end
         ST_FREE_CHK: begin
            if (node_ok) begin
               if (!pend_valid_ff || out_free) begin
                  if (pend_valid_ff) begin
                     load           = 1'b1;
                     load_data.last = 1'b0;
                  end
                  pend_valid_in  = 1'b1;
                  pend_handle_in = q_rd.handle;
                  q_ctl.pop      = 1'b1;
                  freed_cnt_in   = freed_cnt_ff + NCW'(1);
                  state_in       = ST_FREE_RD;
               end
            end else if (out_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               load                   = 1'b1;
               load_data.status       = status_ff;
               load_data.freed_valid  = 1'b0;
               load_data.freed_handle = 32'd0;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_data_in  = load ? load_data : rsp_data_ff;
      rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         epoch_ff      <= '0;
         active_ff     <= '0;
         scan_cnt_ff   <= '0;
         any_ff        <= 1'b0;
         found_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         freed_cnt_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         kind_ff        <= kind_in;
         id_ff          <= id_in;
         epoch_ff       <= epoch_in;
         active_ff      <= active_in;
         scan_cnt_ff    <= scan_cnt_in;
         any_ff         <= any_in;
         oldest_ff      <= oldest_in;
         found_ff       <= found_in;
         found_idx_ff   <= found_idx_in;
         status_ff      <= status_in;
         pend_valid_ff  <= pend_valid_in;
         pend_handle_ff <= pend_handle_in;
         freed_cnt_ff   <= freed_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_data_ff    <= rsp_data_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ERT_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, state_ff != ST_IDLE, "request taken but tracker idle")
   `ERT_ASSERT_IMP(a_freed_ok, clock, reset, rsp_valid && rsp_data.freed_valid, rsp_data.status == ert_pkg::STAT_OK, "freed node with error status")
   `ERT_ASSERT_NEXT(a_epoch_step, clock, reset, req_valid && req_ready && req_data.kind == ert_pkg::KIND_TICK && epoch_ff != '1, epoch_ff == $past(epoch_ff) + 32'd1, "tick did not advance epoch")
   `ERT_ASSERT_IMP(a_free_bound, clock, reset, 1'b1, freed_cnt_ff <= NCW'(ert_pkg::MAX_RESULTS), "free count over limit")

endmodule
